[design/reversible_double_ended_queue_assert.svh]
// Assertion macros used by the queue RTL.
`ifndef REVERSIBLE_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define REVERSIBLE_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define RDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RDQ_ASSERT(label, clk, rst_n, prop, msg)

`define RDQ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[design/rdq_pkg.sv]
`timescale 1ns / 1ps

package rdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_REVERSE   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TO_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

[design/reversible_double_ended_queue.sv]
`timescale 1ns / 1ps
// Reversible double-ended queue of signed 32-bit values.
// Input channel (in_valid/in_ready) carries one operation per beat: func selects
// reverse, push at the back, push at the front, pop from the back or pop from the front,
// and value is the data that a push stores. The output channel (out_valid/out_ready)
// carries popped_value and status for every pop and for every push that finds the
// queue full; a reverse, a successful push and an unused code produce no beat.
// The values live in a single-port synchronous memory of DEPTH entries addressed as
// a ring. Pushes and reverses stream at one per cycle while in_ready stays high.
// A successful pop issues the address to the memory, whose read data is registered,
// and then moves that data into the output register; no operation is accepted in
// between. Error results appear in the cycle after acceptance.
// One output register holds the result; a new operation is accepted while no pop
// read is pending and that register is empty or being taken in the same cycle, so a
// stalled receiver holds off the input channel after one pending beat.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the reverse
// flag at once; no clearing pass is needed since stale entries are never read.
module reversible_double_ended_queue #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rdq_pkg::FUNC_W-1:0]         func,
    input  logic signed [rdq_pkg::DATA_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rdq_pkg::DATA_W-1:0]  popped_value,
    output logic [rdq_pkg::STATUS_W-1:0]       status
);

`include "reversible_double_ended_queue_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(2 * DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [rdq_pkg::DATA_W-1:0]   popped_reg, popped_next;
    logic [rdq_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic                       push_phys_back;
    logic                       pop_phys_back;
    logic [CW-1:0]              count_inc;
    logic [SW-1:0]              sum;
    logic [SW-1:0]              sum_m1;
    logic [AW-1:0]              tail_slot;
    logic [AW-1:0]              last_slot;
    logic [AW-1:0]              head_inc;
    logic [AW-1:0]              head_dec;
    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;
    logic [rdq_pkg::DATA_W-1:0] mem_rdata;

    assign in_ready = !pend_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    assign push_phys_back = (func == rdq_pkg::FUNC_PUSH_BACK) != rev_reg;
    assign pop_phys_back  = (func == rdq_pkg::FUNC_POP_BACK) != rev_reg;

    assign count_inc = count_reg + CW'(1);
    assign sum       = SW'(head_reg) + SW'(count_reg);
    assign sum_m1    = sum - SW'(1);
    assign tail_slot = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
    assign last_slot = (sum_m1 >= SW'(DEPTH)) ? AW'(sum_m1 - SW'(DEPTH)) : AW'(sum_m1);
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        popped_next    = popped_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = head_reg;

        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            popped_next    = mem_rdata;
            status_next    = rdq_pkg::STATUS_OK;
        end

        if (accept)
        begin
            unique case (func) inside
                rdq_pkg::FUNC_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                rdq_pkg::FUNC_PUSH_BACK, rdq_pkg::FUNC_TO_FRONT:
                begin
                    if (full)
                    begin
                        out_valid_next = 1'b1;
                        popped_next    = '0;
                        status_next    = rdq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                        if (push_phys_back)
                        begin
                            mem_addr = tail_slot;
                        end
                        else
                        begin
                            mem_addr  = head_dec;
                            head_next = head_dec;
                        end
                    end
                end
                rdq_pkg::FUNC_POP_BACK, rdq_pkg::FUNC_POP_FRONT:
                begin
                    if (empty)
                    begin
                        out_valid_next = 1'b1;
                        popped_next    = '0;
                        status_next    = rdq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        pend_next  = 1'b1;
                        count_next = count_reg - CW'(1);
                        if (pop_phys_back)
                        begin
                            mem_addr = last_slot;
                        end
                        else
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    rdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (value),
        .rdata (mem_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;

    `RDQ_ASSERT(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH), "entry count above depth")
    `RDQ_ASSERT(a_head_range, clk, rst_n, head_reg <= AW'(DEPTH - 1), "head index out of range")
    `RDQ_ASSERT(a_pend_slot_free, clk, rst_n, pend_reg |-> !out_valid_reg, "output register busy")
    `RDQ_ASSERT(a_pend_delivers, clk, rst_n, pend_reg |=> out_valid_reg, "pop result missing")
    `RDQ_ASSERT(a_push_counts, clk, rst_n, mem_we |=> count_reg == $past(count_inc), "push lost")

endmodule

[design/rdq_store.sv]
`timescale 1ns / 1ps

module rdq_store #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic                      re,
    input  logic [AW-1:0]             addr,
    input  logic [rdq_pkg::DATA_W-1:0] wdata,
    output logic [rdq_pkg::DATA_W-1:0] rdata
);

    logic [rdq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rdq_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
